### rtl/dmtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmtq_pkg
// Shared types and constants of the delayed message timer queue.
// ----------------------------------------------------------------------------
package dmtq_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic [15:0] message_id;
      logic [7:0]  destination;
      logic [31:0] release_time;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_WRITE,
      ST_REJECT,
      ST_TICK_CHECK,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

### rtl/dmtq_queue_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmtq_queue_ram
// Entry store of the timer queue: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmtq_queue_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire dmtq_pkg::entry_type wr_data,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output dmtq_pkg::entry_type      rd_data
);
   import dmtq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/delayed_message_timer_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delayed_message_timer_queue_unit
// Sorted timer queue that holds messages until their release time.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per command. tuser selects insert (0) or
//   one millisecond tick (1); tdata carries release time, destination and
//   message handle for an insert and is ignored for a tick.
//   rsp channel: released messages in release-time order (tlast on the final
//   release of a tick), or one rejected insert (tuser high) when full.
// Entries sit in a circular buffer in RAM; the insertion scan and the release
// walk each have their own time comparator on the RAM read data.
// An insert scans from the tail past each queued entry with a later release
// time, one RAM read per cycle. A tick on an empty queue goes straight back
// to idle; otherwise the release walk runs from the head and stops at an entry
// that is not yet due or when the queue empties; at most 16 releases per tick.
// req_tready is high only while idle.
// Reset clears the counter and so empties the queue; no RAM sweep.
// A stalled rsp channel holds the sequencer; the result register keeps the
// pending transaction until it is taken.
// ----------------------------------------------------------------------------
module delayed_message_timer_queue_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // release_time[31:0], destination[39:32],
                                         // message_id[55:40]
   input  wire logic        req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // destination_res[7:0], message_id_res[23:8]
   output logic             rsp_tuser,   // rejected
   output logic             rsp_tlast    // last
);
   import dmtq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                               input logic [CW-1:0] ofs);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(ofs);
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[AW-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [31:0]          time_now_ff, time_now_in;
   entry_type            ins_ff, ins_in;
   entry_type            held_ff, held_in;
   logic                 held_valid_ff, held_valid_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_dst_ff, out_dst_in;
   logic [15:0]          out_hnd_ff, out_hnd_in;
   logic                 out_rej_ff, out_rej_in;
   logic                 out_last_ff, out_last_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;
   logic [AW-1:0]        rd_addr;
   entry_type            rd_data;
   logic                 out_free;
   logic                 out_load;
   logic                 due;
   logic [AW-1:0]        head_next;

   dmtq_queue_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !out_valid_ff || rsp_tready;
   assign due       = rd_data.release_time <= time_now_ff;
   assign head_next = phys_addr(head_ff, CW'(1));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      time_now_in   = time_now_ff;
      ins_in        = ins_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      n_in          = n_ff;
      out_load      = 1'b0;
      out_dst_in    = out_dst_ff;
      out_hnd_in    = out_hnd_ff;
      out_rej_in    = out_rej_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = phys_addr(head_ff, idx_ff);
      wr_data       = ins_ff;
      rd_addr       = head_ff;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_TICK) begin
                  time_now_in = time_now_ff + 32'd1;
                  n_in        = '0;
                  if (count_ff != '0) begin
                     state_in = ST_TICK_CHECK;
                  end
               end else begin
                  ins_in.release_time = req_tdata[31:0];
                  ins_in.destination  = req_tdata[39:32];
                  ins_in.message_id   = req_tdata[55:40];
                  idx_in              = count_ff;
                  if (count_ff == DEPTH_CNT) begin
                     state_in = ST_REJECT;
                  end else if (count_ff == '0) begin
                     state_in = ST_INS_WRITE;
                  end else begin
                     rd_addr  = phys_addr(head_ff, count_ff - CW'(1));
                     state_in = ST_INS_SCAN;
                  end
               end
            end
         end
         ST_INS_SCAN: begin
            if (rd_data.release_time > ins_ff.release_time) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = idx_ff - CW'(1);
               if (idx_ff == CW'(1)) begin
                  state_in = ST_INS_WRITE;
               end else begin
                  rd_addr = phys_addr(head_ff, idx_ff - CW'(2));
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_INS_WRITE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_IDLE;
         end
         ST_REJECT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_dst_in  = ins_ff.destination;
               out_hnd_in  = ins_ff.message_id;
               out_rej_in  = 1'b1;
               out_last_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_TICK_CHECK: begin
            if (due) begin
               if (!held_valid_ff || out_free) begin
                  if (held_valid_ff) begin
                     out_load    = 1'b1;
                     out_dst_in  = held_ff.destination;
                     out_hnd_in  = held_ff.message_id;
                     out_rej_in  = 1'b0;
                     out_last_in = 1'b0;
                  end
                  held_in       = rd_data;
                  held_valid_in = 1'b1;
                  head_in       = head_next;
                  count_in      = count_ff - CW'(1);
                  n_in          = n_ff + RES_CNT_W'(1);
                  if ((n_ff + RES_CNT_W'(1)) == RES_CNT_W'(MAX_RESULTS)
                      || count_ff == CW'(1)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     rd_addr = head_next;
                  end
               end
            end else if (held_valid_ff) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_dst_in    = held_ff.destination;
               out_hnd_in    = held_ff.message_id;
               out_rej_in    = 1'b0;
               out_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         time_now_ff   <= '0;
         held_valid_ff <= 1'b0;
         n_ff          <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         time_now_ff   <= time_now_in;
         held_valid_ff <= held_valid_in;
         n_ff          <= n_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ins_ff      <= ins_in;
      held_ff     <= held_in;
      out_dst_ff  <= out_dst_in;
      out_hnd_ff  <= out_hnd_in;
      out_rej_ff  <= out_rej_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_hnd_ff, out_dst_ff};
   assign rsp_tuser  = out_rej_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delayed message timer queue. Inserts and ticks
// are driven in random bursts; a scoreboard keeps its own sorted copy of the
// queue, predicts every release and reject, and checks the rsp transactions
// in order while the rsp side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
   import dmtq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 360;
   localparam int LONG_HOLD = 400;

   class timer_queue_scoreboard;
      typedef struct packed {
         logic [7:0]  dst;
         logic [15:0] msg;
         logic        rejected;
         logic        is_last;
      } release_type;

      entry_type   held_msgs[$];
      release_type due_releases[$];
      logic [31:0] tick_count;
      int          errors;

      function new();
         tick_count = '0;
         errors = 0;
      endfunction

      function void accept_command(logic cmd, entry_type item);
         int          pos;
         int          n;
         release_type rel;
         if (cmd == CMD_INSERT) begin
            if (held_msgs.size() >= QUEUE_DEPTH) begin
               rel = '{item.destination, item.message_id, 1'b1, 1'b0};
               due_releases.push_back(rel);
               return;
            end
            pos = 0;
            while (pos < held_msgs.size() && held_msgs[pos].release_time <= item.release_time)
               pos++;
            held_msgs.insert(pos, item);
         end else begin
            tick_count = tick_count + 32'd1;
            n = 0;
            while (n < MAX_RESULTS && held_msgs.size() > 0 &&
                   held_msgs[0].release_time <= tick_count) begin
               rel = '{held_msgs[0].destination, held_msgs[0].message_id, 1'b0, 1'b0};
               due_releases.push_back(rel);
               held_msgs.delete(0);
               n++;
            end
            if (n > 0)
               due_releases[due_releases.size() - 1].is_last = 1'b1;
         end
      endfunction

      function void check_release(logic [23:0] data, logic rejected, logic is_last);
         release_type exp_rel;
         if (due_releases.size() == 0) begin
            $error("unexpected rsp transaction: data %0h rejected %0b last %0b",
                   data, rejected, is_last);
            errors++;
            return;
         end
         exp_rel = due_releases[0];
         due_releases.delete(0);
         if (data[7:0] !== exp_rel.dst) begin
            $error("destination_res: expected %0h, got %0h", exp_rel.dst, data[7:0]);
            errors++;
         end
         if (data[23:8] !== exp_rel.msg) begin
            $error("message_id_res: expected %0h, got %0h", exp_rel.msg, data[23:8]);
            errors++;
         end
         if (rejected !== exp_rel.rejected) begin
            $error("rejected: expected %0b, got %0b", exp_rel.rejected, rejected);
            errors++;
         end
         if (is_last !== exp_rel.is_last) begin
            $error("last: expected %0b, got %0b", exp_rel.is_last, is_last);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_releases.size();
      endfunction

      function int held();
         return held_msgs.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // release_time[31:0], destination[39:32], message_id[55:40]
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // destination_res[7:0], message_id_res[23:8]
   logic        rsp_tuser;        // rejected
   logic        rsp_tlast;        // last

   timer_queue_scoreboard sb;
   bit hold_rsp = 1'b0;
   int burst_left = 0;

   delayed_message_timer_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_release(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // one transaction per call; the burst counter inserts idle gaps between bursts
   task automatic send_item(input logic cmd, input logic [31:0] due,
                            input logic [7:0] dst, input logic [15:0] msg);
      int        gap;
      entry_type item;
      begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         item.release_time = due;
         item.destination = dst;
         item.message_id = msg;
         @(negedge clock);
         req_tvalid <= 1'b1;
         req_tuser <= cmd;
         req_tdata <= item;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sb.accept_command(cmd, item);
      end
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, $urandom, 8'($urandom), 16'($urandom));
   endtask

   task automatic send_insert(input logic [31:0] due);
      send_item(CMD_INSERT, due, 8'($urandom), 16'($urandom));
   endtask

   task automatic drain_releases();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // rsp side: own stall pattern, plus one long hold-off on request
   initial begin : rsp_stall
      int mode;
      int len;
      int cnt;
      cnt = 0;
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(8, 80);
         repeat (len) begin
            @(negedge clock);
            cnt++;
            if (hold_rsp) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
               hold_rsp = 1'b0;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 4) == 0);
                  default: rsp_tready <= (cnt % 3 != 0);
               endcase
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] due;
      int r;
      int i;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // past-due entries at the field extremes, released by the next tick
      send_item(CMD_INSERT, 32'h0000_0000, 8'h00, 16'h0000);
      send_item(CMD_INSERT, 32'h0000_0000, 8'hFF, 16'hFFFF);
      send_tick();
      // equal times keep arrival order; nothing due on the first tick
      due = sb.tick_count;
      send_item(CMD_INSERT, due + 3, 8'h11, 16'h1111);
      send_item(CMD_INSERT, due + 2, 8'h22, 16'h2222);
      send_item(CMD_INSERT, due + 3, 8'h33, 16'h3333);
      repeat (3) send_tick();
      // full queue, one reject, then a tick with the maximum release run
      due = sb.tick_count + 1;
      repeat (QUEUE_DEPTH) send_insert(due);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 8'hA5, 16'h5AA5);
      send_tick();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 150)
            hold_rsp = 1'b1;
         if (i == 300)
            drain_releases();
         r = $urandom_range(0, 99);
         if (i % 70 == 35) begin
            due = sb.tick_count + $urandom_range(1, 3);
            repeat (QUEUE_DEPTH + 1) send_insert(due);
         end else if (sb.held() >= QUEUE_DEPTH && r < 40) begin
            send_insert($urandom);
         end else if (r < 40) begin
            case ($urandom_range(0, 9))
               0: due = $urandom_range(0, sb.tick_count);
               1: due = sb.tick_count + $urandom_range(10, 60);
               default: due = sb.tick_count + $urandom_range(0, 6);
            endcase
            send_insert(due);
         end else begin
            send_tick();
         end
      end

      // entries that never come due fill the queue, then rejects with wide times
      send_insert(32'hFFFF_FFFF);
      while (sb.held() < QUEUE_DEPTH)
         send_insert({1'b1, 31'($urandom)});
      repeat (3) send_insert($urandom);
      repeat (3) send_tick();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
